// ----- hw/rtl/rtlb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtlb_pkg
// Shared types and constants of the row transition line blanker.
// ----------------------------------------------------------------------------
package rtlb_pkg;

	typedef logic [7:0] pixel_t;
	typedef logic [8:0] row_width_t;
	typedef logic [7:0] max_changes_t;

	// configuration register indexes
	typedef logic [0:0] cfg_index_t;
	localparam cfg_index_t REG_ROW_WIDTH   = 1'b0;
	localparam cfg_index_t REG_MAX_CHANGES = 1'b1;

	localparam int CFG_DATA_W = 9;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	localparam row_width_t   ROW_WIDTH_RST   = 9'd136;
	localparam max_changes_t MAX_CHANGES_RST = 8'd10;

	// item commands
	typedef logic [0:0] cmd_t;
	localparam cmd_t CMD_PIXEL = 1'b0;
	localparam cmd_t CMD_DRAIN = 1'b1;

	// one result in flight
	typedef struct packed {
		pixel_t pixel;
		logic   row_end;
		logic   row_blanked;
	} res_t;

endpackage

// ----- hw/rtl/rtlb_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtlb_if
// Valid/ready channels of the blanker: input items and result items.
// ----------------------------------------------------------------------------
interface rtlb_in_if import rtlb_pkg::*; ();
	logic   valid;
	logic   ready;
	cmd_t   cmd;
	pixel_t pixel_in;

	modport source (output valid, output cmd, output pixel_in, input ready);
	modport sink   (input valid, input cmd, input pixel_in, output ready);
endinterface

interface rtlb_out_if import rtlb_pkg::*; ();
	logic   valid;
	logic   ready;
	pixel_t pixel_out;
	logic   row_end;
	logic   row_blanked;

	modport source (output valid, output pixel_out, output row_end, output row_blanked,
		input ready);
	modport sink   (input valid, input pixel_out, input row_end, input row_blanked,
		output ready);
endinterface

// ----- hw/rtl/rtlb_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtlb_ram
// Generic single-port RAM, read-first, registered read data.
// ----------------------------------------------------------------------------
module rtlb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			rdata_q <= mem_q[addr];
			if (we) begin
				mem_q[addr] <= wdata;
			end
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/rtlb_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtlb_cell
// One result cell: holds one transaction and hands it to its neighbor.
// ----------------------------------------------------------------------------
module rtlb_cell import rtlb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  res_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_data
);

	logic valid_q;
	res_t data_q;

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= in_data;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

// ----- hw/rtl/rtlb_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtlb_ctrl
// Row sequencing: column, transition count, held row flags, store access.
// ----------------------------------------------------------------------------
module rtlb_ctrl import rtlb_pkg::*; #(
	parameter int MAX_WIDTH = 256,
	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         acc,
	input  cmd_t         cmd,
	input  pixel_t       pix,
	input  row_width_t   row_width,
	input  max_changes_t max_changes,
	output logic         ram_en,
	output logic         ram_we,
	output logic [CW-1:0] ram_addr,
	output pixel_t       ram_wdata,
	output logic         res_valid,
	output res_t         res_meta
);

	localparam int LW = (CW + 1 > 9) ? CW + 1 : 9;
	localparam int KW = (CW > 8) ? CW : 8;
	localparam logic [CW-1:0] CNT_SAT = CW'(MAX_WIDTH - 1);

	logic [CW-1:0] column_q;
	logic [CW-1:0] count_q;
	pixel_t        prev_q;
	logic          held_q;
	logic          blank_q;
	logic          draining_q;

	logic [LW-1:0] rw_ext;
	logic [LW-1:0] eff_w;
	logic [LW-1:0] last_col;
	logic          is_drain;
	logic          abort;
	logic [CW-1:0] col_eff;
	logic          held_eff;
	logic          last;
	logic          drain_go;
	logic [CW-1:0] cnt_base;
	logic          cnt_inc;
	logic [CW-1:0] cnt_new;
	logic          blank_new;

	always_comb begin
		rw_ext = LW'(row_width);
		if (rw_ext < LW'(2)) begin
			eff_w = LW'(2);
		end else if (rw_ext > LW'(MAX_WIDTH)) begin
			eff_w = LW'(MAX_WIDTH);
		end else begin
			eff_w = rw_ext;
		end
		last_col = eff_w - LW'(1);
	end

	assign is_drain = (cmd == CMD_DRAIN);
	// a pixel arriving during a drain drops the rest of the held row
	assign abort    = !is_drain && draining_q;
	assign col_eff  = abort ? '0 : column_q;
	assign held_eff = held_q && !abort;
	assign last     = LW'(col_eff) >= last_col;
	assign drain_go = is_drain && held_q && (draining_q || column_q == '0);

	assign cnt_base  = abort ? '0 : count_q;
	assign cnt_inc   = (col_eff != '0) && (pix != prev_q) && (cnt_base != CNT_SAT);
	assign cnt_new   = cnt_base + CW'(cnt_inc);
	assign blank_new = KW'(cnt_new) <= KW'(max_changes);

	assign ram_en    = acc;
	assign ram_we    = acc && !is_drain;
	assign ram_addr  = col_eff;
	assign ram_wdata = pix;

	assign res_valid = acc && (is_drain ? drain_go : held_eff);
	always_comb begin
		res_meta.pixel       = '0;
		res_meta.row_end     = last;
		res_meta.row_blanked = blank_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q   <= '0;
			count_q    <= '0;
			prev_q     <= '0;
			held_q     <= 1'b0;
			blank_q    <= 1'b0;
			draining_q <= 1'b0;
		end else if (acc) begin
			if (is_drain) begin
				if (drain_go) begin
					draining_q <= !last;
					if (last) begin
						held_q   <= 1'b0;
						column_q <= '0;
					end else begin
						column_q <= column_q + CW'(1);
					end
				end
			end else begin
				draining_q <= 1'b0;
				prev_q     <= pix;
				if (last) begin
					held_q   <= 1'b1;
					blank_q  <= blank_new;
					count_q  <= '0;
					column_q <= '0;
				end else begin
					held_q   <= held_eff;
					count_q  <= cnt_new;
					column_q <= col_eff + CW'(1);
				end
			end
		end
	end

endmodule

// ----- hw/rtl/row_transition_line_blanker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_transition_line_blanker
// Delays a raster pixel stream by one row and blanks rows with few transitions.
// ----------------------------------------------------------------------------
// Pixels (cmd = pixel) arrive in raster order, row_width per row. Each row is
// written to a line store while the previously held row is read out at the
// same column, so the output is the stream delayed by one row. While a row
// comes in, the neighbor-to-neighbor changes are counted (saturating at
// MAX_WIDTH-1); at its last pixel the row becomes the held row and is marked
// blanked if the count is at or below max_changes. A blanked row goes out as
// zeros with row_blanked set. Drain transactions, issued at a row boundary,
// push the held row out one pixel each; a drain with no held row or mid-row is
// swallowed without a result. A pixel during a drain drops the rest of the
// held row and starts a new one. Throughput is one transaction per clock when
// the result cells have room; the single-port line store does the read of the
// held pixel and the write of the new one at the same address in the same
// cycle. A result is held in cell 0 beside the store read register, then in
// cell 1. The store is not cleared after reset; the first row gives no output.
// Write configuration only while no result is in flight; the block itself
// takes a write in any cycle.
// ----------------------------------------------------------------------------
module row_transition_line_blanker import rtlb_pkg::*; #(
	parameter int MAX_WIDTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  cfg_index_t  cfg_index,
	input  cfg_data_t   cfg_data,
	rtlb_in_if.sink     in_ch,
	rtlb_out_if.source  out_ch
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	// configuration registers
	row_width_t   row_width_q;
	max_changes_t max_changes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q   <= ROW_WIDTH_RST;
			max_changes_q <= MAX_CHANGES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROW_WIDTH:   row_width_q   <= cfg_data[8:0];
				REG_MAX_CHANGES: max_changes_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// input transaction
	logic in_acc;
	logic cell0_in_ready;

	assign in_ch.ready = cell0_in_ready;
	assign in_acc      = in_ch.valid && cell0_in_ready;

	// row sequencing
	logic          ram_en;
	logic          ram_we;
	logic [CW-1:0] ram_addr;
	pixel_t        ram_wdata;
	pixel_t        ram_rdata;
	logic          res_valid;
	res_t          res_meta;

	rtlb_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.acc         (in_acc),
		.cmd         (in_ch.cmd),
		.pix         (in_ch.pixel_in),
		.row_width   (row_width_q),
		.max_changes (max_changes_q),
		.ram_en      (ram_en),
		.ram_we      (ram_we),
		.ram_addr    (ram_addr),
		.ram_wdata   (ram_wdata),
		.res_valid   (res_valid),
		.res_meta    (res_meta)
	);

	// line store: read data only changes on an accepted transaction, so it
	// stays paired with the result sitting in cell 0
	rtlb_ram #(.WIDTH($bits(pixel_t)), .DEPTH(MAX_WIDTH)) u_line_store (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// result chain: cell 0 waits for the store read, cell 1 drives the port
	logic cell0_valid;
	res_t cell0_data;
	logic cell1_in_ready;
	res_t cell1_in;
	logic cell1_valid;
	res_t cell1_data;

	rtlb_cell u_cell0 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_ready  (cell0_in_ready),
		.in_data   (res_meta),
		.out_valid (cell0_valid),
		.out_ready (cell1_in_ready),
		.out_data  (cell0_data)
	);

	always_comb begin
		cell1_in       = cell0_data;
		cell1_in.pixel = cell0_data.row_blanked ? '0 : ram_rdata;
	end

	rtlb_cell u_cell1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cell0_valid),
		.in_ready  (cell1_in_ready),
		.in_data   (cell1_in),
		.out_valid (cell1_valid),
		.out_ready (out_ch.ready),
		.out_data  (cell1_data)
	);

	assign out_ch.valid       = cell1_valid;
	assign out_ch.pixel_out   = cell1_data.pixel;
	assign out_ch.row_end     = cell1_data.row_end;
	assign out_ch.row_blanked = cell1_data.row_blanked;

`ifndef SYNTHESIS
	// a blanked row never leaks stored pixels
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.row_blanked |-> out_ch.pixel_out == '0)
		else $error("blanked row carries nonzero pixel");

	// a transaction that produces a result lands in cell 0
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> cell0_valid)
		else $error("result lost at cell 0");

	// cell 0 moves on into cell 1 whenever cell 1 has room and no new result enters
	assert property (@(posedge clk) disable iff (!arst_n)
		cell0_valid && cell1_in_ready && !res_valid |=> !cell0_valid && cell1_valid)
		else $error("result stuck in cell 0");
`endif

endmodule

// ----- sim/rtlb_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtlb_checker
// Scoreboard of the blanker: mirrors the one-row delay and compares results.
// ----------------------------------------------------------------------------
// Watches the configuration port and both channels. Every accepted input
// transaction advances a local copy of the line store, column, change count
// and held-row flags; the output pixels it causes are queued and checked in
// order against the result transactions.
// ----------------------------------------------------------------------------
module rtlb_checker import rtlb_pkg::*; #(
	parameter int MAX_WIDTH = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  cfg_index_t cfg_index,
	input  cfg_data_t  cfg_data,
	rtlb_in_if         in_ch,
	rtlb_out_if        out_ch,
	output int         errors,
	output int         outstanding
);

	pixel_t       row_copy [MAX_WIDTH];
	int           column;
	pixel_t       prev_pixel;
	int           change_count;
	bit           row_held;
	bit           held_blank;
	bit           draining;
	row_width_t   width_reg;
	max_changes_t threshold_reg;
	res_t         due_pixels [$];

	// one output pixel of the held row
	function automatic void emit_held(int col, bit last);
		res_t r;
		r.pixel       = held_blank ? 8'h00 : row_copy[col % MAX_WIDTH];
		r.row_end     = last;
		r.row_blanked = held_blank;
		due_pixels = {due_pixels, r};
	endfunction

	function automatic void advance_row(cmd_t cmd, pixel_t pix);
		int w;
		bit last;
		w = (width_reg < 2) ? 2 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
		if (cmd == CMD_DRAIN) begin
			// nothing held, or a row is coming in: swallowed
			if (!row_held || (!draining && column != 0))
				return;
			draining = 1'b1;
			last = column >= w - 1;
			emit_held(column, last);
			if (last) begin
				row_held = 1'b0;
				draining = 1'b0;
				column   = 0;
			end else begin
				column++;
			end
			return;
		end
		// a pixel cuts a drain short and opens a fresh row
		if (draining) begin
			draining     = 1'b0;
			row_held     = 1'b0;
			column       = 0;
			change_count = 0;
		end
		last = column >= w - 1;
		if (row_held)
			emit_held(column, last);
		row_copy[column % MAX_WIDTH] = pix;
		if (column != 0 && pix != prev_pixel && change_count < MAX_WIDTH - 1)
			change_count++;
		prev_pixel = pix;
		if (last) begin
			row_held     = 1'b1;
			held_blank   = change_count <= threshold_reg;
			change_count = 0;
			column       = 0;
		end else begin
			column++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			column        = 0;
			prev_pixel    = '0;
			change_count  = 0;
			row_held      = 1'b0;
			held_blank    = 1'b0;
			draining      = 1'b0;
			width_reg     = ROW_WIDTH_RST;
			threshold_reg = MAX_CHANGES_RST;
			due_pixels.delete();
			errors        = 0;
			outstanding   = 0;
		end else begin
			// a transaction at this edge still sees the old settings
			if (in_ch.valid && in_ch.ready)
				advance_row(in_ch.cmd, in_ch.pixel_in);
			if (cfg_we) begin
				case (cfg_index)
				REG_ROW_WIDTH:   width_reg = cfg_data;
				REG_MAX_CHANGES: threshold_reg = cfg_data[7:0];
				default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				if (due_pixels.size() == 0) begin
					$error("unexpected result: pixel_out %0d row_end %0d row_blanked %0d",
						out_ch.pixel_out, out_ch.row_end, out_ch.row_blanked);
					errors++;
				end else begin
					want = due_pixels.pop_front();
					if (out_ch.pixel_out !== want.pixel) begin
						$error("pixel_out: expected %0d, actual %0d", want.pixel,
							out_ch.pixel_out);
						errors++;
					end
					if (out_ch.row_end !== want.row_end) begin
						$error("row_end: expected %0d, actual %0d", want.row_end,
							out_ch.row_end);
						errors++;
					end
					if (out_ch.row_blanked !== want.row_blanked) begin
						$error("row_blanked: expected %0d, actual %0d", want.row_blanked,
							out_ch.row_blanked);
						errors++;
					end
				end
			end
			outstanding = due_pixels.size();
		end
	end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the row transition line blanker.
// ----------------------------------------------------------------------------
// The line store is first filled by one full-width row so that no later
// setting can read a column that was never written. A short directed run
// then covers clamped widths, threshold extremes, swallowed drains, a pixel
// cutting a drain short and a width lowered mid-row. The random part runs
// phases of small rows (wide ones only while the item budget allows) of
// plate-like binary, random or flat content, mostly followed by full drains,
// sometimes by broken drains or noise. The checker beside the block predicts
// and compares.
// ----------------------------------------------------------------------------
module testbench;
	import rtlb_pkg::*;

	localparam int MAX_WIDTH      = 256;
	localparam int TOTAL_ITEMS    = 400;
	localparam int RESULT_LATENCY = 2;   // store read register + output cell
	localparam int SETTLE_CYCLES  = RESULT_LATENCY + 3;
	localparam int WATCHDOG_LIMIT = 4000;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	cfg_index_t cfg_index;
	cfg_data_t  cfg_data;
	int         errors;
	int         outstanding;

	int burst_left   = 0;
	int items_sent   = 0;
	int quiet_cycles = 0;
	int stall_mode   = 0;
	int stall_left   = 0;

	rtlb_in_if  in_ch ();
	rtlb_out_if out_ch ();

	row_transition_line_blanker #(.MAX_WIDTH(MAX_WIDTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	rtlb_checker #(.MAX_WIDTH(MAX_WIDTH)) scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// width the block actually uses for a register value
	function automatic int clamp_width(cfg_data_t w);
		return (w < 2) ? 2 : (w > MAX_WIDTH) ? MAX_WIDTH : int'(w);
	endfunction

	// One input transaction. The sender runs in bursts; between bursts valid
	// drops for a random gap (sometimes none, so back-to-back runs happen).
	task automatic send_item(input cmd_t cmd, input pixel_t pix);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_ch.valid    <= 1'b1;
		in_ch.cmd      <= cmd;
		in_ch.pixel_in <= pix;
		do @(posedge clk); while (!in_ch.ready);
		items_sent++;
	endtask

	// Hold off until every predicted pixel is out, then give rows that cause
	// no result time to leave the pipeline. Sampled at the falling edge so
	// the scoreboard has settled.
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		burst_left = 0;
		do @(negedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Row width always, threshold when asked; only while the block is idle.
	task automatic configure(input cfg_data_t width, input cfg_data_t limit,
		input bit set_limit);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= REG_ROW_WIDTH;
		cfg_data  <= width;
		@(posedge clk);
		if (set_limit) begin
			cfg_index <= REG_MAX_CHANGES;
			cfg_data  <= limit;
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// One row: binary plate-like content with a random change rate (100 gives
	// a fully alternating row, the most transitions a row can have), random
	// bytes, or a flat row.
	task automatic send_row(input int n);
		int     flavor;
		int     pct;
		pixel_t pix;
		flavor = $urandom_range(0, 3);
		pct    = $urandom_range(0, 100);
		pix    = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		for (int i = 0; i < n; i++) begin
			case (flavor)
			0, 1:    if ($urandom_range(0, 99) < pct) pix = ~pix;
			2:       pix = pixel_t'($urandom_range(0, 255));
			default: ;
			endcase
			send_item(CMD_PIXEL, pix);
		end
	endtask

	task automatic send_drains(input int n);
		repeat (n) send_item(CMD_DRAIN, pixel_t'($urandom_range(0, 255)));
	endtask

	// random mix of pixels and drains, mostly landing mid-row
	task automatic send_noise();
		repeat ($urandom_range(1, 5))
			send_item(cmd_t'($urandom_range(0, 1)), pixel_t'($urandom_range(0, 255)));
	endtask

	// Receiver: the ready pattern switches at random to one of four modes:
	// always ready, mostly ready, mostly stalled and a square wave.
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = $urandom_range(8, 120);
			end
			stall_left--;
			case (stall_mode)
			0:       out_ch.ready <= 1'b1;
			1:       out_ch.ready <= $urandom_range(0, 3) != 0;
			2:       out_ch.ready <= $urandom_range(0, 3) == 0;
			default: out_ch.ready <= stall_left[2];
			endcase
		end
	end

	// watchdog: too long without any transaction on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("FAIL row_transition_line_blanker");
				$finish;
			end
		end
	end

	initial begin
		cfg_data_t w;
		cfg_data_t m;
		int        eff;
		int        k;

		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = REG_ROW_WIDTH;
		cfg_data       = '0;
		in_ch.valid    = 1'b0;
		in_ch.cmd      = CMD_PIXEL;
		in_ch.pixel_in = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill every store column with one row at an out-of-range width (acts
		// as the maximum). Threshold stays at its reset value: eleven changes
		// at the head of the row, just above it, so the row must pass.
		configure(9'h1FF, '0, 1'b0);
		for (int i = 0; i < MAX_WIDTH; i++)
			send_item(CMD_PIXEL, (i < 12 && i % 2 == 0) ? 8'h00 : 8'hFF);

		// width 0 clamps to 2, threshold 0: one change passes, none blanks
		configure('0, '0, 1'b1);
		send_item(CMD_PIXEL, 8'h00);   // head of the filled row comes out
		send_item(CMD_PIXEL, 8'hFF);
		send_item(CMD_PIXEL, 8'hFF);
		send_item(CMD_PIXEL, 8'hFF);   // flat row: held as blanked
		send_drains(2);                // zeros with row_blanked
		send_drains(1);                // nothing held: swallowed
		send_item(CMD_PIXEL, 8'hA5);
		send_item(CMD_PIXEL, 8'h5A);
		send_item(CMD_PIXEL, 8'h12);
		send_drains(1);                // mid-row with a held row: swallowed
		send_item(CMD_PIXEL, 8'h34);
		send_drains(1);                // starts a drain
		send_item(CMD_PIXEL, 8'h77);   // cuts it short, no result
		send_item(CMD_PIXEL, 8'h88);

		// width 1 clamps to 2; upper data bit beyond the threshold register
		configure(9'd1, 9'h1FF, 1'b1);
		send_item(CMD_PIXEL, 8'h01);
		send_item(CMD_PIXEL, 8'h80);

		// width lowered mid-row: the next pixel closes the row at once
		configure(9'd5, 9'd1, 1'b1);
		send_item(CMD_PIXEL, 8'h10);
		send_item(CMD_PIXEL, 8'h20);
		send_item(CMD_PIXEL, 8'h30);
		configure(9'd2, '0, 1'b0);
		send_item(CMD_PIXEL, 8'h40);
		send_drains(2);

		// random phases: new setting, a few rows, then mostly a full drain
		while (items_sent < TOTAL_ITEMS) begin
			case ($urandom_range(0, 15))
			0:       w = cfg_data_t'($urandom_range(0, 1));
			1:       w = cfg_data_t'($urandom_range(MAX_WIDTH, 511));
			2:       w = ROW_WIDTH_RST;
			default: w = cfg_data_t'($urandom_range(2, 12));
			endcase
			// keep the run near its item budget
			if (2 * clamp_width(w) > TOTAL_ITEMS - items_sent)
				w = cfg_data_t'($urandom_range(2, 12));
			eff = clamp_width(w);
			case ($urandom_range(0, 7))
			0:       m = '0;
			1:       m = 9'h0FF;
			default: m = cfg_data_t'($urandom_range(0, eff - 1));
			endcase
			configure(w, m, 1'b1);
			if ($urandom_range(0, 4) == 0)
				send_noise();
			repeat ((eff > 16) ? 1 : $urandom_range(1, 4))
				send_row(eff);
			case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				send_drains(eff);
			end
			5, 6: begin
				// broken drain: a pixel lands part way through
				k = $urandom_range(1, eff - 1);
				send_drains(k);
				send_item(CMD_PIXEL, pixel_t'($urandom_range(0, 255)));
			end
			7, 8:    send_noise();
			default: ;
			endcase
		end

		wait_idle();
		if (errors == 0 && outstanding == 0)
			$display("PASS row_transition_line_blanker");
		else
			$display("FAIL row_transition_line_blanker");
		$finish;
	end

endmodule

// ----- row_transition_line_blanker.f -----
hw/rtl/rtlb_pkg.sv
hw/rtl/rtlb_if.sv
hw/rtl/rtlb_ram.sv
hw/rtl/rtlb_cell.sv
hw/rtl/rtlb_ctrl.sv
hw/rtl/row_transition_line_blanker.sv
sim/rtlb_checker.sv
sim/testbench.sv
